// File: design/mhc_pkg.sv
package mhc_pkg;

	// Number of vectoring iterations of the CORDIC (8 to 24).
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int STEP_W       = 5;

	// Datapath widths.
	localparam int RAW_W  = 16;              // joined sensor reading
	localparam int SPAN_W = RAW_W + 1;       // max - min
	localparam int REL_W  = RAW_W + 2;       // reading minus bound midpoint
	localparam int PROD_W = REL_W + SPAN_W;  // weighted axis value
	localparam int VEC_W  = PROD_W + 3;      // CORDIC x/y with gain headroom
	localparam int ATAN_W = 22;              // widest arctangent table entry
	localparam int ANG_W  = 26;              // Q16 degrees, signed

	localparam int CNT_W  = 10;
	localparam int HEAD_W = 9;

	localparam logic signed [RAW_W-1:0] BOUND_MIN_RESET = 16'sh7FFF;
	localparam logic signed [RAW_W-1:0] BOUND_MAX_RESET = 16'sh8000;
	localparam logic [CNT_W-1:0]        CAL_SAMPLES_RESET = 10'd100;

	localparam logic signed [ANG_W-1:0] DEG_Q16_90  = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG_Q16_180 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG_Q16_360 = 26'sd23592960;
	localparam logic [HEAD_W-1:0]       HEADING_MAX = 9'd360;

	// Status bit positions.
	localparam int STAT_NEW  = 0;
	localparam int STAT_OVF  = 1;
	localparam int STAT_SKIP = 2;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_CAL     = 2'd1,
		OP_HEADING = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		RC_OK      = 3'd0,
		RC_OVF     = 3'd1,
		RC_SKIP    = 3'd2,
		RC_NO_DATA = 3'd3,
		RC_SPAN    = 3'd4
	} result_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL_A,
		S_MUL_B,
		S_PRE,
		S_ITER,
		S_FIN,
		S_DONE
	} state_t;

	// Rounded atan(2^-i) in Q16 degrees.
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// File: design/magnetometer_heading_calibrated_core.sv
// Compass heading core with hard-iron calibration. Each input transfer carries an
// opcode, three sensor status bits and the raw X/Y bytes; each produces exactly one
// output transfer. Opcode 0 clears the min/max bounds and the sample count. Opcode 1
// with new data widens the bounds until cal_samples samples are counted. Opcode 2
// with new data centers the reading on the bound midpoints, weights each axis by the
// span of the other and returns atan2 as a whole-degree heading in 0..360 (code 4
// if a span is not positive). Status priority is overflow, then skipped, then new
// data. Items other than headings go from S_EVAL straight to S_DONE; a heading item
// passes through S_MUL_A, S_MUL_B, S_PRE, the S_ITER iterations and S_FIN, with
// the single shared adder/shifter running one CORDIC iteration per cycle after two
// passes through one shared 18x17 multiplier. When the weighted Y term is zero the
// angle is exact and the iterations are skipped. The core is back in idle, and
// ready again, as the output register is loaded. A new input transfer is taken as
// soon as the core is back in idle, even while the previous result still waits in
// the output register. cal_samples is written through cfg_we/cfg_wdata and resets
// to 100; the user must write it only while the core is idle, the core itself
// does not enforce this.
module magnetometer_heading_calibrated_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mhc_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [2:0]                   sensor_status,
	input  logic [7:0]                   x_low_byte,
	input  logic [7:0]                   x_high_byte,
	input  logic [7:0]                   y_low_byte,
	input  logic [7:0]                   y_high_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   result_code,
	output logic [mhc_pkg::HEAD_W-1:0]   heading_deg,
	output logic [mhc_pkg::CNT_W-1:0]    samples_taken,
	output logic                         calibration_done
);
	import mhc_pkg::*;

	state_t state_q, state_d;

	// Captured input item.
	opcode_t                  op_q;
	logic [2:0]               status_q;
	logic signed [RAW_W-1:0]  raw_x_q, raw_y_q;

	// Calibration state.
	logic [CNT_W-1:0]         cal_samples_q;
	logic signed [RAW_W-1:0]  x_min_q, x_max_q, y_min_q, y_max_q;
	logic [CNT_W-1:0]         sample_count_q;

	// Heading datapath.
	logic signed [REL_W-1:0]  rx_q, ry_q;
	logic signed [SPAN_W-1:0] sx_q, sy_q;
	logic signed [PROD_W-1:0] a_q, b_q;
	logic signed [VEC_W-1:0]  cx_q, cy_q;
	logic signed [ANG_W-1:0]  z_q;
	logic [STEP_W-1:0]        step_q;

	result_code_t             code_q;
	logic [HEAD_W-1:0]        heading_q;

	// Output register.
	logic                     out_valid_q;
	result_code_t             out_code_q;
	logic [HEAD_W-1:0]        out_heading_q;
	logic [CNT_W-1:0]         out_samples_q;
	logic                     out_done_q;

	// Control.
	logic                     accept;
	logic                     out_load;
	logic                     heading_go;
	logic                     cal_take;
	result_code_t             code_d;

	// Combinational datapath.
	logic signed [SPAN_W-1:0] sx_d, sy_d, sum_x, sum_y, mid_x, mid_y;
	logic signed [REL_W-1:0]  rx_d, ry_d;
	logic signed [REL_W-1:0]  mul_l;
	logic signed [SPAN_W-1:0] mul_r;
	logic signed [PROD_W-1:0] prod;
	logic signed [VEC_W-1:0]  a_ext, b_ext, cx_sh, cy_sh;
	logic signed [ANG_W-1:0]  atan_ext, ang;
	logic                     new_data;

	assign accept = in_valid && in_ready;

	// Span and centered reading; the midpoint halving truncates toward zero.
	always_comb begin
		sx_d  = SPAN_W'(x_max_q) - SPAN_W'(x_min_q);
		sy_d  = SPAN_W'(y_max_q) - SPAN_W'(y_min_q);
		sum_x = SPAN_W'(x_max_q) + SPAN_W'(x_min_q);
		sum_y = SPAN_W'(y_max_q) + SPAN_W'(y_min_q);
		mid_x = (sum_x + $signed(SPAN_W'(sum_x[SPAN_W-1]))) >>> 1;
		mid_y = (sum_y + $signed(SPAN_W'(sum_y[SPAN_W-1]))) >>> 1;
		rx_d  = REL_W'(raw_x_q) - REL_W'(mid_x);
		ry_d  = REL_W'(raw_y_q) - REL_W'(mid_y);
	end

	// Status priority and the decision made on a captured item.
	always_comb begin
		new_data   = 1'b0;
		code_d     = RC_OK;
		heading_go = 1'b0;
		if (op_q == OP_CAL || op_q == OP_HEADING) begin
			if (status_q[STAT_OVF]) begin
				code_d = RC_OVF;
			end else if (status_q[STAT_SKIP]) begin
				code_d = RC_SKIP;
			end else if (!status_q[STAT_NEW]) begin
				code_d = RC_NO_DATA;
			end else begin
				new_data = 1'b1;
				if (op_q == OP_HEADING) begin
					if (sx_d <= 0 || sy_d <= 0) begin
						code_d = RC_SPAN;
					end else begin
						heading_go = 1'b1;
					end
				end
			end
		end
		cal_take = new_data && op_q == OP_CAL && sample_count_q < cal_samples_q;
	end

	// Shared multiplier: ry*sx first, then rx*sy.
	assign mul_l = (state_q == S_MUL_A) ? ry_q : rx_q;
	assign mul_r = (state_q == S_MUL_A) ? sx_q : sy_q;
	assign prod  = mul_l * mul_r;

	// Shared CORDIC adder/shifter operands.
	assign a_ext    = VEC_W'(a_q);
	assign b_ext    = VEC_W'(b_q);
	assign cx_sh    = cx_q >>> step_q;
	assign cy_sh    = cy_q >>> step_q;
	assign atan_ext = $signed(ANG_W'(atan_q16(step_q)));
	assign ang      = (z_q <= 0) ? z_q + DEG_Q16_360 : z_q;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = heading_go ? S_MUL_A : S_DONE;
			end
			S_MUL_A: state_d = S_MUL_B;
			S_MUL_B: state_d = S_PRE;
			S_PRE: begin
				state_d = (a_q == 0) ? S_FIN : S_ITER;
			end
			S_ITER: begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register and calibration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_samples_q  <= CAL_SAMPLES_RESET;
			x_min_q        <= BOUND_MIN_RESET;
			x_max_q        <= BOUND_MAX_RESET;
			y_min_q        <= BOUND_MIN_RESET;
			y_max_q        <= BOUND_MAX_RESET;
			sample_count_q <= '0;
		end else begin
			if (cfg_we) begin
				cal_samples_q <= cfg_wdata;
			end
			if (state_q == S_EVAL) begin
				if (op_q == OP_RESTART) begin
					x_min_q        <= BOUND_MIN_RESET;
					x_max_q        <= BOUND_MAX_RESET;
					y_min_q        <= BOUND_MIN_RESET;
					y_max_q        <= BOUND_MAX_RESET;
					sample_count_q <= '0;
				end else if (cal_take) begin
					sample_count_q <= sample_count_q + CNT_W'(1);
					if (raw_x_q < x_min_q) x_min_q <= raw_x_q;
					if (raw_x_q > x_max_q) x_max_q <= raw_x_q;
					if (raw_y_q < y_min_q) y_min_q <= raw_y_q;
					if (raw_y_q > y_max_q) y_max_q <= raw_y_q;
				end
			end
		end
	end

	// Item capture and heading datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode_t'(opcode);
			status_q <= sensor_status;
			raw_x_q  <= $signed({x_high_byte, x_low_byte});
			raw_y_q  <= $signed({y_high_byte, y_low_byte});
		end
		case (state_q)
			S_EVAL: begin
				code_q    <= code_d;
				heading_q <= '0;
				rx_q      <= rx_d;
				ry_q      <= ry_d;
				sx_q      <= sx_d;
				sy_q      <= sy_d;
			end
			S_MUL_A: a_q <= prod;
			S_MUL_B: b_q <= prod;
			S_PRE: begin
				step_q <= '0;
				if (a_q == 0) begin
					z_q <= (b_q < 0) ? DEG_Q16_180 : '0;
				end else if (b_q < 0) begin
					if (a_q > 0) begin
						cx_q <= a_ext;
						cy_q <= -b_ext;
						z_q  <= DEG_Q16_90;
					end else begin
						cx_q <= -a_ext;
						cy_q <= b_ext;
						z_q  <= -DEG_Q16_90;
					end
				end else begin
					cx_q <= b_ext;
					cy_q <= a_ext;
					z_q  <= '0;
				end
			end
			S_ITER: begin
				step_q <= step_q + STEP_W'(1);
				if (cy_q >= 0) begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					z_q  <= z_q + atan_ext;
				end else begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					z_q  <= z_q - atan_ext;
				end
			end
			S_FIN: begin
				if (ang[ANG_W-2:16] > (ANG_W-17)'(HEADING_MAX)) begin
					heading_q <= HEADING_MAX;
				end else begin
					heading_q <= ang[16 +: HEAD_W];
				end
			end
			default: ;
		endcase
	end

	// Output register; the next item may be taken while it still waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_code_q    <= code_q;
			out_heading_q <= heading_q;
			out_samples_q <= sample_count_q;
			out_done_q    <= (sample_count_q >= cal_samples_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign result_code      = out_code_q;
	assign heading_deg      = out_heading_q;
	assign samples_taken    = out_samples_q;
	assign calibration_done = out_done_q;

	// A heading other than zero only comes with a good result.
	a_heading_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && heading_deg != '0 |-> result_code == RC_OK)
		else $error("heading reported with an error code");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_deg <= HEADING_MAX)
		else $error("heading above 360 degrees");

	// The completion flag agrees with the count while no configuration write happens.
	a_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(cfg_we) && !cfg_we |->
			calibration_done == (samples_taken >= cal_samples_q))
		else $error("calibration_done disagrees with samples_taken");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ITER |-> step_q < STEP_W'(CORDIC_STEPS))
		else $error("CORDIC step counter overran");

endmodule
